// ----- hw/rtl/plst_pkg.sv -----
// Shared constants, codes and control structs for the positional list store.
package plst_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Fixed field widths of the stream payload.
    localparam int OP_W    = 3;
    localparam int POS_W   = 4;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 2;
    localparam int HIT_W   = 4;
    localparam int TOTAL_W = 5;
    localparam int FILL_W  = 5;

    // Width in which a position and the count can be compared without loss.
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 3'd0,
        OP_APPEND = 3'd1,
        OP_INSERT = 3'd2,
        OP_DELETE = 3'd3,
        OP_SEARCH = 3'd4,
        OP_READ   = 3'd5
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_BAD_POS   = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture the input transaction
        logic exec;   // commit a non-search operation and load the result
        logic cmp;    // register the per-entry match vector
        logic tally;  // encode the match vector into the result
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_search;
    } dp_stat_t;

endpackage

// ----- hw/rtl/plst_ctrl.sv -----
// Controller state machine of the positional list store.
module plst_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  plst_pkg::dp_stat_t stat,
    output plst_pkg::ctl_cmd_t cmd
);
    import plst_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_TALLY
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;
    logic   out_free;

    // The result register can take a new result when empty or being drained.
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb
    begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (stat.is_search)
                begin
                    cmd.cmp    = 1'b1;
                    state_next = ST_TALLY;
                end
                else if (out_free)
                begin
                    cmd.exec      = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_TALLY:
            begin
                if (out_free)
                begin
                    cmd.tally     = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

// ----- hw/rtl/plst_datapath.sv -----
// Datapath of the positional list store: entry cells, count, match logic and result register.
module plst_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  plst_pkg::ctl_cmd_t                   cmd,
    output plst_pkg::dp_stat_t                   stat,
    input  logic [plst_pkg::OP_W-1:0]            opcode,
    input  logic [plst_pkg::POS_W-1:0]           position,
    input  logic signed [plst_pkg::VAL_W-1:0]    operand_value,
    output plst_pkg::status_t                    status,
    output logic signed [plst_pkg::VAL_W-1:0]    read_value,
    output logic [plst_pkg::HIT_W-1:0]           hit_index,
    output logic [plst_pkg::TOTAL_W-1:0]         match_total,
    output logic [plst_pkg::FILL_W-1:0]          fill_count
);
    import plst_pkg::*;

    op_t                          in_op_reg;
    logic [POS_W-1:0]             in_pos_reg;
    logic signed [DATA_WIDTH-1:0] in_word_reg;

    logic signed [DATA_WIDTH-1:0] cells_reg [DEPTH];
    logic signed [DATA_WIDTH-1:0] cells_next [DEPTH];
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;
    logic [DEPTH-1:0]             match_reg;
    logic [DEPTH-1:0]             match_next;

    status_t                      exec_status;
    logic signed [VAL_W-1:0]      exec_read;
    logic                         pos_ok;
    logic                         list_full;
    logic [IDX_W-1:0]             pos_idx;
    logic [IDX_W-1:0]             tail_idx;
    logic [IDX_W-1:0]             hit_idx;
    logic [CNT_W-1:0]             hit_total;

    status_t                      out_status_reg;
    logic signed [VAL_W-1:0]      out_read_reg;
    logic [HIT_W-1:0]             out_hit_reg;
    logic [TOTAL_W-1:0]           out_total_reg;
    logic [FILL_W-1:0]            out_fill_reg;

    assign stat.is_search = (in_op_reg == OP_SEARCH);

    assign pos_ok    = CMP_W'(in_pos_reg) < CMP_W'(count_reg);
    assign list_full = (count_reg == CNT_W'(DEPTH));
    // Only used when the position is below the count, so it fits the index.
    assign pos_idx   = IDX_W'(in_pos_reg);
    assign tail_idx  = IDX_W'(count_reg);

    // Operation on the row of cells: every cell picks itself, a neighbor or the new word.
    always_comb
    begin
        cells_next  = cells_reg;
        count_next  = count_reg;
        exec_status = STAT_OK;
        exec_read   = '0;
        case (in_op_reg)
            OP_CLEAR:
            begin
                count_next = '0;
            end
            OP_APPEND:
            begin
                if (list_full)
                begin
                    exec_status = STAT_FULL;
                end
                else
                begin
                    cells_next[tail_idx] = in_word_reg;
                    count_next           = count_reg + CNT_W'(1);
                end
            end
            OP_INSERT:
            begin
                if (!pos_ok)
                begin
                    exec_status = STAT_BAD_POS;
                end
                else if (list_full)
                begin
                    exec_status = STAT_FULL;
                end
                else
                begin
                    for (int k = 1; k < DEPTH; k++)
                    begin
                        if (IDX_W'(k) > pos_idx)
                        begin
                            cells_next[k] = cells_reg[k-1];
                        end
                    end
                    cells_next[pos_idx] = in_word_reg;
                    count_next          = count_reg + CNT_W'(1);
                end
            end
            OP_DELETE:
            begin
                if (!pos_ok)
                begin
                    exec_status = STAT_BAD_POS;
                end
                else
                begin
                    for (int k = 0; k < DEPTH - 1; k++)
                    begin
                        if (IDX_W'(k) >= pos_idx)
                        begin
                            cells_next[k] = cells_reg[k+1];
                        end
                    end
                    count_next = count_reg - CNT_W'(1);
                end
            end
            OP_READ:
            begin
                if (!pos_ok)
                begin
                    exec_status = STAT_BAD_POS;
                end
                else
                begin
                    exec_read = VAL_W'(cells_reg[pos_idx]);
                end
            end
            default:
            begin
                exec_status = STAT_OK;
            end
        endcase
    end

    // Each cell compares against the key; entries at or above the count are ignored.
    always_comb
    begin
        for (int k = 0; k < DEPTH; k++)
        begin
            match_next[k] = (cells_reg[k] == in_word_reg) && (CNT_W'(k) < count_reg);
        end
    end

    // Lowest matching index and number of matches from the registered match vector.
    always_comb
    begin
        hit_idx   = '0;
        hit_total = '0;
        for (int k = DEPTH - 1; k >= 0; k--)
        begin
            if (match_reg[k])
            begin
                hit_idx = IDX_W'(k);
            end
        end
        for (int k = 0; k < DEPTH; k++)
        begin
            hit_total = hit_total + CNT_W'(match_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_op_reg   <= op_t'(opcode);
            in_pos_reg  <= position;
            in_word_reg <= DATA_WIDTH'(operand_value);
        end
        if (cmd.exec)
        begin
            cells_reg <= cells_next;
        end
        if (cmd.cmp)
        begin
            match_reg <= match_next;
        end
        if (cmd.exec)
        begin
            out_status_reg <= exec_status;
            out_read_reg   <= exec_read;
            out_hit_reg    <= '0;
            out_total_reg  <= '0;
            out_fill_reg   <= FILL_W'(count_next);
        end
        else if (cmd.tally)
        begin
            out_status_reg <= (match_reg != '0) ? STAT_OK : STAT_NOT_FOUND;
            out_read_reg   <= '0;
            out_hit_reg    <= HIT_W'(hit_idx);
            out_total_reg  <= TOTAL_W'(hit_total);
            out_fill_reg   <= FILL_W'(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            count_reg <= count_next;
        end
    end

    assign status      = out_status_reg;
    assign read_value  = out_read_reg;
    assign hit_index   = out_hit_reg;
    assign match_total = out_total_reg;
    assign fill_count  = out_fill_reg;

`ifndef ASSERT_OFF
    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count exceeds the list depth");

    a_reject_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && (exec_status == STAT_BAD_POS || exec_status == STAT_FULL)
        |=> $stable(count_reg))
        else $error("rejected operation changed the entry count");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && in_op_reg == OP_CLEAR |=> count_reg == '0)
        else $error("clear left entries in the list");

    a_search_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cmp |=> $stable(count_reg))
        else $error("search changed the entry count");
`endif

endmodule

// ----- hw/rtl/positional_list_store.sv -----
// Top level of the positional list store: stream ports, controller and datapath.
//
// The block keeps an ordered list of up to DEPTH signed words and answers one result
// transaction for each input transaction: clear, append, insert, delete, search or read.
// An accepted item is captured in the input registers, then executed against a row of entry
// cells that all shift or compare at once, and its result is loaded into the output register;
// a search first registers the match vector and then encodes it in an extra step. The block
// takes no new item until the last one has reached the output register. The next item is
// accepted while a result still waits in the output register; only a second result
// stalls, in the execute or encode step, until the first has been taken.
module positional_list_store (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // position [3:0], operand_value [35:4], zero [39:36]
    input  logic [2:0]  s_tuser,   // opcode [2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // read_value [31:0], hit_index [35:32],
                                   // match_total [40:36], fill_count [45:41], zero [47:46]
    output logic [1:0]  m_tuser    // status [1:0]
);
    import plst_pkg::*;

    ctl_cmd_t                cmd;
    dp_stat_t                stat;
    status_t                 status;
    logic signed [VAL_W-1:0] read_value;
    logic [HIT_W-1:0]        hit_index;
    logic [TOTAL_W-1:0]      match_total;
    logic [FILL_W-1:0]       fill_count;

    plst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    plst_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .opcode        (s_tuser),
        .position      (s_tdata[3:0]),
        .operand_value (s_tdata[35:4]),
        .status        (status),
        .read_value    (read_value),
        .hit_index     (hit_index),
        .match_total   (match_total),
        .fill_count    (fill_count)
    );

    assign m_tdata = {2'b00, fill_count, match_total, hit_index, read_value};
    assign m_tuser = status;

endmodule

// ----- sim/tb_positional_list_store.sv -----
// Testbench for positional_list_store: random stream traffic checked against a list predictor.
`timescale 1ns / 1ps

module tb_positional_list_store;
    import plst_pkg::*;

    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;
    localparam int RANDOM_OPS = 900;
    localparam int MAX_WAIT   = 18;
    localparam int TAIL_CYCLES = 20;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [2:0]  op;
        logic [3:0]  pos;
        logic [31:0] value;
    } list_op_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] read_value;
        logic [3:0]  hit_index;
        logic [4:0]  match_total;
        logic [4:0]  fill_count;
    } list_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;    // position [3:0], operand_value [35:4], zero [39:36]
    logic [2:0]  s_tuser = '0;    // opcode [2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;         // read_value [31:0], hit_index [35:32],
                                  // match_total [40:36], fill_count [45:41], zero [47:46]
    logic [1:0]  m_tuser;         // status [1:0]

    // Predicted contents of the list.
    logic [31:0] list_words [DEPTH];
    int          list_len = 0;

    list_op_t     op_backlog [$];
    list_result_t predicted_replies [$];
    logic [31:0]  key_pool [8];

    int  ops_taken = 0;
    int  mismatch_count = 0;
    int  src_wait = 0;
    bit  src_lazy = 1'b1;
    int  sink_hold = 0;
    bit  sink_lazy = 1'b0;
    int  idle_cycles = 0;

    positional_list_store dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic list_result_t apply_list_op(logic [2:0] op, logic [3:0] pos,
                                                   logic [31:0] value);
        list_result_t r;
        int k;
        r = '0;
        r.status = STAT_OK;
        case (op)
            OP_CLEAR:
                list_len = 0;
            OP_APPEND:
                if (list_len >= DEPTH)
                    r.status = STAT_FULL;
                else
                begin
                    list_words[list_len] = value;
                    list_len++;
                end
            OP_INSERT:
                // A bad position wins over a full list.
                if (int'(pos) >= list_len)
                    r.status = STAT_BAD_POS;
                else if (list_len >= DEPTH)
                    r.status = STAT_FULL;
                else
                begin
                    for (k = list_len; k > int'(pos); k--)
                        list_words[k] = list_words[k-1];
                    list_words[pos] = value;
                    list_len++;
                end
            OP_DELETE:
                if (int'(pos) >= list_len)
                    r.status = STAT_BAD_POS;
                else
                begin
                    for (k = int'(pos) + 1; k < list_len; k++)
                        list_words[k-1] = list_words[k];
                    list_len--;
                end
            OP_SEARCH:
            begin
                for (k = 0; k < list_len; k++)
                    if (list_words[k] == value)
                    begin
                        if (r.match_total == 0)
                            r.hit_index = k[3:0];
                        r.match_total = r.match_total + 5'd1;
                    end
                if (r.match_total == 0)
                    r.status = STAT_NOT_FOUND;
            end
            OP_READ:
                if (int'(pos) >= list_len)
                    r.status = STAT_BAD_POS;
                else
                    r.read_value = list_words[pos];
            default:
                ;
        endcase
        r.fill_count = list_len[4:0];
        return r;
    endfunction

    function automatic void enqueue_op(logic [2:0] op, logic [3:0] pos, logic [31:0] value);
        list_op_t item;
        item.op = op;
        item.pos = pos;
        item.value = value;
        op_backlog.push_back(item);
    endfunction

    // Values come mostly from a small pool so that searches find repeated matches.
    function automatic logic [31:0] pick_value();
        if ($urandom_range(0, 9) < 6)
            return key_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    function automatic logic [3:0] pick_pos(int len);
        int p;
        if ($urandom_range(0, 4) == 0)
            return 4'($urandom_range(0, 15));
        p = $urandom_range(0, len);
        return (p > 15) ? 4'd15 : 4'(p);
    endfunction

    initial
    begin : stimulus
        int gen_len;
        int r;
        int i;
        int total_ops;
        logic [2:0] op;
        logic [3:0] pos;
        logic [31:0] value;

        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        key_pool[2] = 32'h7FFF_FFFF;
        key_pool[3] = 32'h8000_0000;
        for (i = 4; i < 8; i++)
            key_pool[i] = $urandom;

        // Empty list: every positional operation is out of range, search misses.
        enqueue_op(OP_CLEAR,  4'd0, 32'h0);
        enqueue_op(OP_READ,   4'd0, 32'h0);
        enqueue_op(OP_DELETE, 4'd0, 32'h0);
        enqueue_op(OP_INSERT, 4'd0, 32'h1);
        enqueue_op(OP_SEARCH, 4'd0, 32'h0);
        enqueue_op(OP_APPEND, 4'd0, 32'h8000_0000);
        enqueue_op(OP_APPEND, 4'd0, 32'h7FFF_FFFF);
        enqueue_op(OP_APPEND, 4'd0, 32'hFFFF_FFFF);
        enqueue_op(OP_APPEND, 4'd0, 32'h0000_0000);
        enqueue_op(OP_INSERT, 4'd0, 32'h7FFF_FFFF);
        enqueue_op(OP_INSERT, 4'd4, 32'h1234_5678);
        enqueue_op(OP_SEARCH, 4'd0, 32'h7FFF_FFFF);
        enqueue_op(OP_SEARCH, 4'd0, 32'h0000_0000);
        enqueue_op(OP_READ,   4'd15, 32'h0);
        enqueue_op(OP_READ,   4'd5, 32'h0);
        enqueue_op(OP_READ,   4'd1, 32'h0);
        enqueue_op(OP_DELETE, 4'd0, 32'h0);
        enqueue_op(OP_DELETE, 4'd4, 32'h0);
        enqueue_op(OP_SPARE_LO, 4'd3, 32'hDEAD_BEEF);
        enqueue_op(OP_SPARE_HI, 4'd15, 32'hFFFF_FFFF);
        enqueue_op(OP_CLEAR,  4'd0, 32'h0);

        // Random part: growth outweighs deletes so the list fills up often,
        // while the occasional clear brings it back to the short end.
        gen_len = 0;
        for (i = 0; i < RANDOM_OPS; i++)
        begin
            r = $urandom_range(0, 99);
            pos = pick_pos(gen_len);
            value = pick_value();
            if (r < 3)
                op = OP_CLEAR;
            else if (r < 28)
                op = OP_APPEND;
            else if (r < 46)
                op = OP_INSERT;
            else if (r < 62)
                op = OP_DELETE;
            else if (r < 80)
                op = OP_SEARCH;
            else if (r < 99)
                op = OP_READ;
            else
                op = ($urandom_range(0, 1) == 0) ? OP_SPARE_LO : OP_SPARE_HI;
            enqueue_op(op, pos, value);
            case (op)
                OP_CLEAR:  gen_len = 0;
                OP_APPEND: if (gen_len < DEPTH) gen_len++;
                OP_INSERT: if (int'(pos) < gen_len && gen_len < DEPTH) gen_len++;
                OP_DELETE: if (int'(pos) < gen_len) gen_len--;
                default:   ;
            endcase
        end
        total_ops = op_backlog.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (ops_taken < total_ops)
            @(posedge clk);
        while (predicted_replies.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    always @(posedge clk)
    begin : source_side
        list_op_t nxt;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predicted_replies.push_back(apply_list_op(s_tuser, s_tdata[3:0],
                                                          s_tdata[35:4]));
                ops_taken++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (src_wait > 0)
                begin
                    src_wait--;
                    s_tvalid <= 1'b0;
                end
                else if (op_backlog.size() > 0)
                begin
                    nxt = op_backlog.pop_front();
                    s_tuser <= nxt.op;
                    s_tdata <= {4'b0, nxt.value, nxt.pos};
                    s_tvalid <= 1'b1;
                    if ($urandom_range(0, 49) == 0)
                        src_lazy = !src_lazy;
                    src_wait = src_lazy ? $urandom_range(0, MAX_WAIT) : 0;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : sink_side
        list_result_t want;
        int n;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (m_tvalid && m_tready)
        begin
            if (predicted_replies.size() == 0)
            begin
                $error("unexpected result transaction: tdata %h tuser %h", m_tdata, m_tuser);
                mismatch_count++;
            end
            else
            begin
                want = predicted_replies.pop_front();
                if (m_tuser !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    mismatch_count++;
                end
                if (m_tdata[31:0] !== want.read_value)
                begin
                    $error("read_value: expected %0d, got %0d",
                           $signed(want.read_value), $signed(m_tdata[31:0]));
                    mismatch_count++;
                end
                if (m_tdata[35:32] !== want.hit_index)
                begin
                    $error("hit_index: expected %0d, got %0d", want.hit_index, m_tdata[35:32]);
                    mismatch_count++;
                end
                if (m_tdata[40:36] !== want.match_total)
                begin
                    $error("match_total: expected %0d, got %0d",
                           want.match_total, m_tdata[40:36]);
                    mismatch_count++;
                end
                if (m_tdata[45:41] !== want.fill_count)
                begin
                    $error("fill_count: expected %0d, got %0d",
                           want.fill_count, m_tdata[45:41]);
                    mismatch_count++;
                end
            end
            if ($urandom_range(0, 49) == 0)
                sink_lazy = !sink_lazy;
            n = sink_lazy ? $urandom_range(0, MAX_WAIT) : 0;
            sink_hold <= n;
            m_tready <= (n == 0);
        end
        else if (sink_hold > 0)
        begin
            sink_hold <= sink_hold - 1;
            m_tready <= (sink_hold == 1);
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // Ends a hung run: no transaction on either side for far longer than any legal stall.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

endmodule
